>>> rtl/oal_pkg.sv
// Package with the request and result types and operation codes of the ordered array list.
package oal_pkg;

    // Operation codes carried in the request opcode field.
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_UPDATE = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_FIND   = 3'd4;

    // Fixed field widths of the request and result transfers.
    localparam int unsigned POS_W   = 5;
    localparam int unsigned NAME_W  = 64;
    localparam int unsigned PAY_W   = 32;
    localparam int unsigned COUNT_W = 6;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [POS_W-1:0]  position;
        logic              append;
        logic [NAME_W-1:0] entry_name;
        logic [PAY_W-1:0]  entry_payload;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic               found;
        logic [POS_W-1:0]   found_position;
        logic [NAME_W-1:0]  read_name;
        logic [PAY_W-1:0]   read_payload;
        logic [COUNT_W-1:0] entry_count;
    } t_res;

endpackage

>>> rtl/oal_mem.sv
// Entry store: one write port and one read port with registered read data.
module oal_mem
    import oal_pkg::*;
#(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned WIDTH = 96,
    parameter int unsigned AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data registered and available in the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/oal_seq.sv
// Sequencer that runs each operation as read and write-back steps on the entry store.
module oal_seq
    import oal_pkg::*;
#(
    parameter int unsigned CAPACITY     = 32,
    parameter int unsigned NAME_BITS    = 64,
    parameter int unsigned PAYLOAD_BITS = 32,
    parameter int unsigned AW           = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  t_req                              i_req,
    output logic                              o_busy,
    output logic                              o_done,
    output t_res                              o_res,
    output logic                              o_we,
    output logic [AW-1:0]                     o_waddr,
    output logic [NAME_BITS+PAYLOAD_BITS-1:0] o_wdata,
    output logic                              o_re,
    output logic [AW-1:0]                     o_raddr,
    input  logic [NAME_BITS+PAYLOAD_BITS-1:0] i_rdata
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = (CW > POS_W + 1) ? CW : POS_W + 1;
    localparam int unsigned EW = NAME_BITS + PAYLOAD_BITS;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_INS_STEP = 8'b0000_0010,
        S_INS_WR   = 8'b0000_0100,
        S_DEL_STEP = 8'b0000_1000,
        S_DEL_WR   = 8'b0001_0000,
        S_RD_WAIT  = 8'b0010_0000,
        S_FIND_RD  = 8'b0100_0000,
        S_FIND_CMP = 8'b1000_0000
    } t_state;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_idx, n_idx;
    logic [AW-1:0]           r_at, n_at;
    logic [NAME_BITS-1:0]    r_name, n_name;
    logic [PAYLOAD_BITS-1:0] r_pay, n_pay;

    logic [XW-1:0]           pos_x;
    logic [XW-1:0]           count_x;
    logic [XW-1:0]           at_x;
    logic                    pos_valid;
    logic [NAME_BITS-1:0]    rd_name;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic                    idx_last;

    // Request position and count brought to a common width for the range checks.
    assign pos_x     = XW'(i_req.position);
    assign count_x   = XW'(r_count);
    assign at_x      = i_req.append ? count_x : pos_x;
    assign pos_valid = pos_x < count_x;
    assign rd_name   = i_rdata[EW-1:PAYLOAD_BITS];
    assign rd_pay    = i_rdata[PAYLOAD_BITS-1:0];
    assign idx_last  = (CW'(r_idx) + CW'(1)) == r_count;

    assign o_busy = r_state != S_IDLE;

    // Next-state logic: one store access per cycle, shifts take a read and a write per entry.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_at    = r_at;
        n_name  = r_name;
        n_pay   = r_pay;
        o_done  = 1'b0;
        o_res   = '0;
        o_we    = 1'b0;
        o_waddr = r_idx;
        o_wdata = {r_name, r_pay};
        o_re    = 1'b0;
        o_raddr = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_name = NAME_BITS'(i_req.entry_name);
                    n_pay  = PAYLOAD_BITS'(i_req.entry_payload);
                    case (i_req.opcode)
                        OP_INSERT: begin
                            if (count_x < XW'(CAPACITY) && at_x <= count_x) begin
                                n_at    = AW'(at_x);
                                n_idx   = AW'(count_x);
                                n_state = S_INS_STEP;
                            end else begin
                                o_done = 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            if (pos_valid) begin
                                n_idx   = AW'(pos_x);
                                n_state = S_DEL_STEP;
                            end else begin
                                o_done = 1'b1;
                            end
                        end
                        OP_UPDATE: begin
                            o_done = 1'b1;
                            if (pos_valid) begin
                                o_we     = 1'b1;
                                o_waddr  = AW'(pos_x);
                                o_wdata  = {NAME_BITS'(i_req.entry_name),
                                            PAYLOAD_BITS'(i_req.entry_payload)};
                                o_res.ok = 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (pos_valid) begin
                                o_re    = 1'b1;
                                o_raddr = AW'(pos_x);
                                n_state = S_RD_WAIT;
                            end else begin
                                o_done = 1'b1;
                            end
                        end
                        OP_FIND: begin
                            if (r_count != '0) begin
                                n_idx   = '0;
                                n_state = S_FIND_RD;
                            end else begin
                                o_done = 1'b1;
                            end
                        end
                        default: begin
                            o_done = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_STEP: begin
                if (r_idx == r_at) begin
                    // The gap is open: place the new entry.
                    o_we     = 1'b1;
                    n_count  = r_count + CW'(1);
                    o_done   = 1'b1;
                    o_res.ok = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = r_idx - AW'(1);
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_we    = 1'b1;
                o_wdata = i_rdata;
                n_idx   = r_idx - AW'(1);
                n_state = S_INS_STEP;
            end
            S_DEL_STEP: begin
                if (idx_last) begin
                    n_count  = r_count - CW'(1);
                    o_done   = 1'b1;
                    o_res.ok = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = r_idx + AW'(1);
                    n_state = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                o_we    = 1'b1;
                o_wdata = i_rdata;
                n_idx   = r_idx + AW'(1);
                n_state = S_DEL_STEP;
            end
            S_RD_WAIT: begin
                o_done             = 1'b1;
                o_res.ok           = 1'b1;
                o_res.read_name    = NAME_W'(rd_name);
                o_res.read_payload = PAY_W'(rd_pay);
                n_state            = S_IDLE;
            end
            S_FIND_RD: begin
                o_re    = 1'b1;
                n_state = S_FIND_CMP;
            end
            S_FIND_CMP: begin
                if (rd_name == r_name) begin
                    o_done               = 1'b1;
                    o_res.ok             = 1'b1;
                    o_res.found          = 1'b1;
                    o_res.found_position = POS_W'(r_idx);
                    n_state              = S_IDLE;
                end else if (idx_last) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_FIND_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_res.entry_count = COUNT_W'(n_count);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers of the operation in progress.
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_at   <= n_at;
        r_name <= n_name;
        r_pay  <= n_pay;
    end

    // The list never holds more entries than the store has.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    // Read and write never meet at one address, so no forwarding is needed.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_we && o_re) |-> (o_waddr != o_raddr))
        else $error("store read and write collide");

    // The count only moves at the end of an operation.
    a_count_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |=> $stable(r_count))
        else $error("entry count changed mid-operation");

    // A shift write always follows the read that fetched its data.
    a_shift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_WR || r_state == S_DEL_WR) |->
        ($past(r_state) == S_INS_STEP || $past(r_state) == S_DEL_STEP))
        else $error("shift write without preceding read");

    // A match is always reported as a success.
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.found) |-> o_res.ok)
        else $error("found without ok");

endmodule

>>> rtl/ordered_array_list.sv
// Top level of the ordered array list: sequencer, entry store and result register.
//
// Usage: drive a request on i_req and raise start; the request transfer takes place
// at a rising edge where start is high and busy is low. Exactly one result per
// request appears on o_res for a single cycle, marked by o_valid; the receiver
// cannot hold it off, so it must take it in that cycle.
// How each operation runs from the accepting edge to the strobe of the result register:
//   update, and any rejected request: finished in the accepting cycle
//   read: one store read of position p, then the result
//   insert at position p into n entries: shifts entries p to n-1 up by one, then writes at p
//   delete at position p from n entries: shifts entries p+1 to n-1 down by one
//   find: reads and compares entries from position 0 to the first match or the last entry
// Each entry moved or compared costs a read and a write-back or compare step,
// set by the single-port-each-way entry store with its registered read data.
// busy falls as the last step finishes, so the next request may be accepted
// while the previous result is still on the outputs.
// Reset empties the list at once; stored entries keep stale contents, which
// are never visible because only positions below the count are read.
module ordered_array_list
    import oal_pkg::*;
#(
    parameter int unsigned CAPACITY     = 32,
    parameter int unsigned NAME_BITS    = 64,
    parameter int unsigned PAYLOAD_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_res o_res
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned EW = NAME_BITS + PAYLOAD_BITS;

    logic          seq_done;
    t_res          seq_res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;
    logic          r_valid;
    t_res          r_res;

    // Operation sequencer.
    oal_seq #(
        .CAPACITY     (CAPACITY),
        .NAME_BITS    (NAME_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .AW           (AW)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .o_busy  (busy),
        .o_done  (seq_done),
        .o_res   (seq_res),
        .o_we    (mem_we),
        .o_waddr (mem_waddr),
        .o_wdata (mem_wdata),
        .o_re    (mem_re),
        .o_raddr (mem_raddr),
        .i_rdata (mem_rdata)
    );

    // Entry store holding name and payload side by side.
    oal_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (EW),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Result register: holds each result transfer for exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= seq_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_res <= seq_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
